[rtl/bgnc_pkg.sv]
// ----------------------------------------------------------------------------
// bgnc_pkg - shared definitions for the binary grid neighbour count core
// Register indexes, field widths, reset values and default size limits.
// ----------------------------------------------------------------------------
package bgnc_pkg;

	// default size limits, handed to the top level as parameter defaults
	localparam int DEF_MAX_WIDTH  = 32;
	localparam int DEF_MAX_HEIGHT = 1024;

	// configuration register widths and port sizes
	localparam int FRAME_WIDTH_BITS  = 6;
	localparam int FRAME_HEIGHT_BITS = 11;
	localparam int CFG_DATA_BITS     = 11;
	localparam int CFG_INDEX_BITS    = 1;
	localparam int TOTAL_BITS        = 4;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

	// register reset values
	localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RST  = 6'd30;
	localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 11'd12;

endpackage

[rtl/binary_grid_neighbour_count_core.sv]
// ----------------------------------------------------------------------------
// binary_grid_neighbour_count_core - eight-neighbour count over a binary grid
// Cells stream in raster order; each result gives a cell's set-neighbour count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cell_set) takes one cell per transaction
//   in raster order. Output channel (out_valid/out_ready) gives one result per
//   transaction: cell_row, cell_col, neighbour_total, own_set, run_end (last
//   result caused by an input) and frame_end (frame's final cell).
//   The result for cell (r, c) leaves when cell (r+1, c+1) arrives; the end of
//   a row also yields the last column of the row above, and the last cell of
//   a frame drains the whole final row.
//   The first result of a cell passes from the pending-result registers into
//   the output register. Throughput is one cell per cycle for cells giving at
//   most one result, while the receiver keeps up; further results of a cell
//   are walked out one per cycle by the result sequencer, and the input waits
//   until the last of them is loaded.
//   A new cell is taken in the same cycle as the previous cell's last result
//   moves to the output register, so a held result does not block it alone.
//   Reset clears the row stores, counters and out_valid and loads frame_width
//   30, frame_height 12. When the receiver stalls, the output register holds
//   and the sequencer and then the input stall behind it. The user writes
//   configuration (cfg_we/cfg_index/cfg_data) only while idle; not enforced.
// ----------------------------------------------------------------------------
module binary_grid_neighbour_count_core #(
	parameter int MAX_WIDTH  = bgnc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bgnc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bgnc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [bgnc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cell_set,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [$clog2(MAX_HEIGHT)-1:0]        cell_row,
	output logic [$clog2(MAX_WIDTH)-1:0]         cell_col,
	output logic [bgnc_pkg::TOTAL_BITS-1:0]      neighbour_total,
	output logic                                 own_set,
	output logic                                 run_end,
	output logic                                 frame_end
);
	import bgnc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// configuration
	logic [FRAME_WIDTH_BITS-1:0]  width_q;
	logic [FRAME_HEIGHT_BITS-1:0] height_q;
	logic [CW-1:0]                last_col;
	logic [RW-1:0]                last_row;
	logic [MAX_WIDTH-1:0]         width_mask;

	// grid state
	logic [MAX_WIDTH-1:0] older_q, middle_q, newest_q, newest_set;
	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;

	// pending results of the last accepted cell
	logic                 job_a_q, job_b_q, job_d_q;
	logic [MAX_WIDTH-1:0] job_older_q, job_middle_q, job_newest_q;
	logic [RW-1:0]        job_row_q;
	logic [CW-1:0]        job_col_q, job_last_col_q, job_dcol_q;

	// output register
	logic                  out_valid_q;
	logic [RW-1:0]         res_row_q;
	logic [CW-1:0]         res_col_q;
	logic [TOTAL_BITS-1:0] res_total_q;
	logic                  res_own_q, res_run_end_q, res_frame_end_q;

	logic row_end, frame_done, in_cell_ok, emit_a, emit_b, emit_d, in_fire;
	logic sel_a, sel_b, sel_d, res_last, job_busy, out_load, job_done;
	logic [CW-1:0]         res_col;
	logic [RW-1:0]         res_row;
	logic [MAX_WIDTH-1:0]  above, cur, below;
	logic [2:0]            win_above, win_cur, win_below;
	logic [TOTAL_BITS-1:0] res_total;

	// effective sizes: zero acts as one, oversize clamps to the limit
	always_comb begin
		if (width_q == '0) begin
			last_col = '0;
		end else if (32'(width_q) > MAX_WIDTH) begin
			last_col = CW'(MAX_WIDTH - 1);
		end else begin
			last_col = CW'(width_q - 6'd1);
		end
		if (height_q == '0) begin
			last_row = '0;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			last_row = RW'(MAX_HEIGHT - 1);
		end else begin
			last_row = RW'(height_q - 11'd1);
		end
		for (int i = 0; i < MAX_WIDTH; i++) begin
			width_mask[i] = (CW'(i) <= last_col);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[FRAME_WIDTH_BITS-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[FRAME_HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// decode of the arriving cell
	always_comb begin
		row_end    = (col_q >= last_col);
		frame_done = row_end && (row_q >= last_row);
		in_cell_ok = (col_q <= last_col);
		newest_set = newest_q;
		if (cell_set && in_cell_ok) begin
			newest_set[col_q] = 1'b1;
		end
		emit_a = (row_q != '0) && (col_q != '0) && in_cell_ok;
		emit_b = (row_q != '0) && row_end;
		emit_d = frame_done;
	end

	// result sequencer: diagonal cell first, then row-above tail, then drain
	always_comb begin
		sel_a    = job_a_q;
		sel_b    = !job_a_q && job_b_q;
		sel_d    = !job_a_q && !job_b_q && job_d_q;
		job_busy = job_a_q || job_b_q || job_d_q;
		if (sel_a) begin
			res_col  = job_col_q - CW'(1);
			res_last = !job_b_q && !job_d_q;
		end else if (sel_b) begin
			res_col  = job_last_col_q;
			res_last = !job_d_q;
		end else begin
			res_col  = job_dcol_q;
			res_last = (job_dcol_q == job_last_col_q);
		end
		res_row = sel_d ? job_row_q : job_row_q - RW'(1);
		above   = sel_d ? job_middle_q : job_older_q;
		cur     = sel_d ? job_newest_q : job_middle_q;
		below   = sel_d ? '0 : job_newest_q;
		// zero padding on both sides and the width mask cover the frame's side edges
		win_above = 3'({1'b0, above, 1'b0} >> res_col);
		win_cur   = 3'({1'b0, cur, 1'b0} >> res_col);
		win_below = 3'({1'b0, below, 1'b0} >> res_col);
		res_total = TOTAL_BITS'(win_above[0]) + TOTAL_BITS'(win_above[1])
			+ TOTAL_BITS'(win_above[2]) + TOTAL_BITS'(win_cur[0])
			+ TOTAL_BITS'(win_cur[2]) + TOTAL_BITS'(win_below[0])
			+ TOTAL_BITS'(win_below[1]) + TOTAL_BITS'(win_below[2]);
	end

	assign out_load = job_busy && (!out_valid_q || out_ready);
	assign job_done = out_load && res_last;
	assign in_ready = !job_busy || job_done;
	assign in_fire  = in_valid && in_ready;

	// grid state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q    <= '0;
			middle_q   <= '0;
			newest_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
			job_a_q    <= 1'b0;
			job_b_q    <= 1'b0;
			job_d_q    <= 1'b0;
			job_dcol_q <= '0;
		end else begin
			if (in_fire) begin
				if (frame_done) begin
					older_q  <= '0;
					middle_q <= '0;
					newest_q <= '0;
					col_q    <= '0;
					row_q    <= '0;
				end else if (row_end) begin
					older_q  <= middle_q;
					middle_q <= newest_set;
					newest_q <= '0;
					col_q    <= '0;
					row_q    <= row_q + RW'(1);
				end else begin
					newest_q <= newest_set;
					col_q    <= col_q + CW'(1);
				end
			end
			if (in_fire) begin
				job_a_q    <= emit_a;
				job_b_q    <= emit_b;
				job_d_q    <= emit_d;
				job_dcol_q <= '0;
			end else if (out_load) begin
				if (sel_a) begin
					job_a_q <= 1'b0;
				end else if (sel_b) begin
					job_b_q <= 1'b0;
				end else if (res_last) begin
					job_d_q <= 1'b0;
				end else begin
					job_dcol_q <= job_dcol_q + CW'(1);
				end
			end
		end
	end

	// snapshot of the rows for the pending results, masked to the frame width
	always_ff @(posedge clk) begin
		if (in_fire) begin
			job_older_q    <= older_q & width_mask;
			job_middle_q   <= middle_q & width_mask;
			job_newest_q   <= newest_set & width_mask;
			job_row_q      <= row_q;
			job_col_q      <= col_q;
			job_last_col_q <= last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_row_q       <= res_row;
			res_col_q       <= res_col;
			res_total_q     <= res_total;
			res_own_q       <= win_cur[1];
			res_run_end_q   <= res_last;
			res_frame_end_q <= sel_d && res_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_row        = res_row_q;
	assign cell_col        = res_col_q;
	assign neighbour_total = res_total_q;
	assign own_set         = res_own_q;
	assign run_end         = res_run_end_q;
	assign frame_end       = res_frame_end_q;

	// input only held off while results of the previous cell are queued
	a_stall_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> job_busy)
		else $error("input stalled with no pending results");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_total_q <= TOTAL_BITS'(8)))
		else $error("neighbour total above eight");

	a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_frame_end_q) |-> res_run_end_q)
		else $error("frame end not on last result of the transaction");

	a_drain_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		job_d_q |-> (job_dcol_q <= job_last_col_q))
		else $error("drain column past last column");

	a_frame_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_done) |=> (col_q == '0 && row_q == '0 && newest_q == '0))
		else $error("grid state not cleared after frame end");

endmodule
